// ===== rtl/utf8_vietnamese_diacritic_fold_top_assert.svh =====
// assertion macros shared by the utf-8 fold rtl
`ifndef UTF8_VIETNAMESE_DIACRITIC_FOLD_TOP_ASSERT_SVH
`define UTF8_VIETNAMESE_DIACRITIC_FOLD_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define UVDF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uvdf assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define UVDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uvdf assertion failed");

`endif

// ===== rtl/uvdf_pkg.sv =====
// package: types, byte codes and fold table for the utf-8 fold block
package uvdf_pkg;

  localparam logic [7:0] BYTE_NUL      = 8'h00;
  localparam logic [7:0] CHAR_UNKNOWN  = 8'h3F;
  localparam logic [7:0] LEAD2_MASK    = 8'hE0;
  localparam logic [7:0] LEAD2_CODE    = 8'hC0;
  localparam logic [7:0] LEAD3_MASK    = 8'hF0;
  localparam logic [7:0] LEAD3_CODE    = 8'hE0;
  localparam logic [1:0] PEND_NONE     = 2'd0;
  localparam logic [1:0] PEND_ONE      = 2'd1;
  localparam logic [1:0] PEND_TWO      = 2'd2;

  typedef struct packed {
    logic       vld;
    logic [7:0] chr;
    logic       is_end;
  } uvdf_res_t;

  // base letter of an accented code point, zero when not in the table
  function automatic logic [7:0] fold_letter(input logic [15:0] cp);
    logic [7:0] r;
    begin
      case (cp)
        16'h00E0, 16'h00E1, 16'h1EA1, 16'h1EB1, 16'h1EA3, 16'h00E2,
        16'h1EB3, 16'h00E3, 16'h1EA5, 16'h1EA7, 16'h1EA9, 16'h1EAD,
        16'h1EAF, 16'h1EB5, 16'h1EB7, 16'h00E4, 16'h00E5, 16'h1EAB,
        16'h0103: r = 8'h61;
        16'h00E8, 16'h00E9, 16'h1EB9, 16'h1EBF, 16'h1EC1, 16'h1EBD,
        16'h1EC3, 16'h00EA, 16'h1EBB, 16'h1EC5, 16'h1EC7, 16'h00EB: r = 8'h65;
        16'h00EC, 16'h00ED, 16'h1EC9, 16'h1ECB, 16'h0129, 16'h00EE,
        16'h00EF: r = 8'h69;
        16'h00F2, 16'h00F3, 16'h1ECD, 16'h1ECF, 16'h1ED1, 16'h00F4,
        16'h1ED7, 16'h1ED3, 16'h1ED5, 16'h00F5, 16'h1EDD, 16'h1EDF,
        16'h1EE1, 16'h1EE3, 16'h00F6, 16'h01A1, 16'h1ED9, 16'h1EDB: r = 8'h6F;
        16'h00F9, 16'h00FA, 16'h1EE7, 16'h1EE9, 16'h0169, 16'h01B0,
        16'h1EEB, 16'h1EED, 16'h00FB, 16'h1EE5, 16'h1EEF, 16'h00FC,
        16'h1EF1: r = 8'h75;
        16'h00FD, 16'h1EF3, 16'h1EF7, 16'h1EF9, 16'h1EF5: r = 8'h79;
        16'h0111: r = 8'h64;
        16'h00C0, 16'h00C1, 16'h1EA0, 16'h1EB0, 16'h1EA2, 16'h00C2,
        16'h1EAC, 16'h1EB2, 16'h00C3, 16'h1EA6, 16'h1EA8, 16'h1EAA,
        16'h1EAE, 16'h1EB4, 16'h1EB6, 16'h00C4, 16'h00C5, 16'h0102,
        16'h1EA4: r = 8'h41;
        16'h00C8, 16'h00C9, 16'h1EB8, 16'h1EBE, 16'h1EC0, 16'h1EBC,
        16'h1EC2, 16'h00CA, 16'h1EBA, 16'h1EC4, 16'h1EC6, 16'h00CB: r = 8'h45;
        16'h00CC, 16'h00CD, 16'h1EC8, 16'h1ECA, 16'h0128, 16'h00CE,
        16'h00CF: r = 8'h49;
        16'h00D2, 16'h00D3, 16'h1ECC, 16'h1ED0, 16'h00D4, 16'h1ED6,
        16'h1ED2, 16'h1ED4, 16'h00D5, 16'h1EE0, 16'h1EE2, 16'h00D6,
        16'h01A0, 16'h1EDC, 16'h1EDE, 16'h1EDA, 16'h1ED8, 16'h1ECE: r = 8'h4F;
        16'h00D9, 16'h00DA, 16'h1EE4, 16'h1EE6, 16'h1EE8, 16'h0168,
        16'h01AF, 16'h1EEA, 16'h1EEC, 16'h00DB, 16'h1EEE, 16'h00DC,
        16'h1EF0: r = 8'h55;
        16'h00DD, 16'h1EF2, 16'h1EF6, 16'h1EF8, 16'h1EF4: r = 8'h59;
        16'h0110: r = 8'h44;
        default: r = 8'h00;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/uvdf_decode.sv =====
// utf-8 sequence state and per-byte decode with diacritic fold
module uvdf_decode
  import uvdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output uvdf_res_t  res_o
);

  logic [1:0]  pend_r, pend_nxt;
  logic [15:0] code_r, code_nxt;
  logic [15:0] cp;
  logic [7:0]  base;
  logic        emit_code;

  always_comb begin
    pend_nxt   = pend_r;
    code_nxt   = code_r;
    cp         = {8'h00, byte_i};
    emit_code  = 1'b0;
    res_o      = '0;
    if (byte_i == BYTE_NUL) begin
      pend_nxt     = PEND_NONE;
      code_nxt     = '0;
      res_o.vld    = 1'b1;
      res_o.is_end = 1'b1;
    end else if (pend_r != PEND_NONE) begin
      code_nxt  = {code_r[9:0], byte_i[5:0]};
      pend_nxt  = pend_r - 2'd1;
      cp        = code_nxt;
      emit_code = (pend_r == PEND_ONE);
    end else if (!byte_i[7]) begin
      emit_code = 1'b1;
    end else if ((byte_i & LEAD2_MASK) == LEAD2_CODE) begin
      code_nxt = {11'd0, byte_i[4:0]};
      pend_nxt = PEND_ONE;
    end else if ((byte_i & LEAD3_MASK) == LEAD3_CODE) begin
      code_nxt = {12'd0, byte_i[3:0]};
      pend_nxt = PEND_TWO;
    end else begin
      res_o.vld = 1'b1;
      res_o.chr = CHAR_UNKNOWN;
    end
    base = fold_letter(cp);
    if (emit_code) begin
      res_o.vld = 1'b1;
      res_o.chr = (base != 8'h00) ? base : cp[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
      code_r <= '0;
    end else if (step_i) begin
      pend_r <= pend_nxt;
      code_r <= code_nxt;
    end
  end

`include "utf8_vietnamese_diacritic_fold_top_assert.svh"

  `UVDF_ASSERT_NOW(a_pend_range, 1'b1, pend_r != 2'd3)
  `UVDF_ASSERT_NEXT(a_nul_clears, step_i && (byte_i == BYTE_NUL), pend_r == PEND_NONE)
  `UVDF_ASSERT_NOW(a_no_res_mid_seq, (pend_r == PEND_TWO) && (byte_i != BYTE_NUL), !res_o.vld)

endmodule

// ===== rtl/utf8_vietnamese_diacritic_fold_top.sv =====
// Folds a UTF-8 byte stream (1-, 2- and 3-byte sequences) to unaccented 8-bit
// characters, one byte accepted per clock with valid/ready on both sides. A byte
// is held in an input register, decoded and looked up in the fold table
// combinationally, and its result (if any) lands in the output register when
// that is free or being taken. Lead and middle bytes of a
// sequence give no result; a zero byte gives the terminator with out_is_end set.
// in_ready falls only while the output register holds a result that is not
// taken and the input register holds a byte that would produce another.
module utf8_vietnamese_diacritic_fold_top
  import uvdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_is_end
);

  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_byte_r;
  logic       out_vld_r, out_vld_nxt;
  logic [7:0] out_char_r;
  logic       out_end_r;
  logic       s1_adv;
  uvdf_res_t  res;

  uvdf_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (s1_adv),
    .byte_i (s1_byte_r),
    .res_o  (res)
  );

  assign s1_adv   = s1_vld_r && (!res.vld || !out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_ready) begin
      s1_vld_nxt = in_valid;
    end
    out_vld_nxt = out_vld_r;
    if (s1_adv && res.vld) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte;
    end
    if (s1_adv && res.vld) begin
      out_char_r <= res.chr;
      out_end_r  <= res.is_end;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_char   = out_char_r;
  assign out_is_end = out_end_r;

`include "utf8_vietnamese_diacritic_fold_top_assert.svh"

  `UVDF_ASSERT_NOW(a_end_is_nul, out_vld_r && out_end_r, out_char_r == BYTE_NUL)
  `UVDF_ASSERT_NEXT(a_nul_gives_end, s1_adv && (s1_byte_r == BYTE_NUL), out_vld_r && out_end_r)
  `UVDF_ASSERT_NEXT(a_s1_holds, s1_vld_r && !s1_adv, s1_vld_r && $stable(s1_byte_r))
  `UVDF_ASSERT_NOW(a_no_overwrite, s1_adv && res.vld && out_vld_r, out_ready)

endmodule

// ===== tb/tb_utf8_vietnamese_diacritic_fold_top.sv =====
// testbench for the utf-8 vietnamese diacritic fold block with a self-checking scoreboard
module tb_utf8_vietnamese_diacritic_fold_top
  import uvdf_pkg::*;
();

  localparam int IDLE_LIMIT  = 1000;
  localparam int N_PHASES    = 6;
  localparam int PHASE_BYTES = 205;

  typedef enum {TX_STREAM, TX_BURSTY, TX_SPARSE} tx_mode_t;
  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG_STALL} rx_mode_t;

  localparam tx_mode_t PHASE_TX [N_PHASES] = '{TX_STREAM, TX_BURSTY, TX_SPARSE,
                                               TX_BURSTY, TX_STREAM, TX_SPARSE};
  localparam rx_mode_t PHASE_RX [N_PHASES] = '{RX_ALWAYS, RX_RANDOM, RX_PERIODIC,
                                               RX_LONG_STALL, RX_RANDOM, RX_ALWAYS};

  localparam bit [7:0] DIRECTED [25] = '{
    8'h41, 8'h7F, 8'h01, 8'h00,
    8'hC3, 8'hA0,
    8'hE1, 8'hBA, 8'hA4,
    8'hE1, 8'hBB, 8'h8E,
    8'h80, 8'hFF, 8'hF0,
    8'hE1, 8'hBA, 8'h00,
    8'hC4, 8'hC1,
    8'hC0, 8'h80,
    8'hEF, 8'hBF, 8'hBF
  };

  // lower-case accented code points and their base letters, {code, letter}
  localparam bit [23:0] SMALL_FOLDS [75] = '{
    24'h00E0_61, 24'h00E1_61, 24'h00E2_61, 24'h00E3_61, 24'h00E4_61, 24'h00E5_61,
    24'h0103_61, 24'h1EA1_61, 24'h1EA3_61, 24'h1EA5_61, 24'h1EA7_61, 24'h1EA9_61,
    24'h1EAB_61, 24'h1EAD_61, 24'h1EAF_61, 24'h1EB1_61, 24'h1EB3_61, 24'h1EB5_61,
    24'h1EB7_61,
    24'h00E8_65, 24'h00E9_65, 24'h00EA_65, 24'h00EB_65, 24'h1EB9_65, 24'h1EBB_65,
    24'h1EBD_65, 24'h1EBF_65, 24'h1EC1_65, 24'h1EC3_65, 24'h1EC5_65, 24'h1EC7_65,
    24'h00EC_69, 24'h00ED_69, 24'h00EE_69, 24'h00EF_69, 24'h0129_69, 24'h1EC9_69,
    24'h1ECB_69,
    24'h00F2_6F, 24'h00F3_6F, 24'h00F4_6F, 24'h00F5_6F, 24'h00F6_6F, 24'h01A1_6F,
    24'h1ECD_6F, 24'h1ECF_6F, 24'h1ED1_6F, 24'h1ED3_6F, 24'h1ED5_6F, 24'h1ED7_6F,
    24'h1ED9_6F, 24'h1EDB_6F, 24'h1EDD_6F, 24'h1EDF_6F, 24'h1EE1_6F, 24'h1EE3_6F,
    24'h00F9_75, 24'h00FA_75, 24'h00FB_75, 24'h00FC_75, 24'h0169_75, 24'h01B0_75,
    24'h1EE5_75, 24'h1EE7_75, 24'h1EE9_75, 24'h1EEB_75, 24'h1EED_75, 24'h1EEF_75,
    24'h1EF1_75,
    24'h00FD_79, 24'h1EF3_79, 24'h1EF5_79, 24'h1EF7_79, 24'h1EF9_79,
    24'h0111_64
  };

  typedef struct packed {
    bit [7:0] chr;
    bit       term;
  } folded_char_t;

  class fold_tracker;
    bit [1:0]     cont_left;
    bit [15:0]    code_acc;
    bit [7:0]     base_of [bit [15:0]];
    bit [15:0]    accented [$];
    folded_char_t chars_due [$];
    int           n_checked;
    int           n_folded;
    int           n_ends;
    int           n_errors;

    function new();
      bit [15:0] cp;
      bit [7:0]  ch;
      foreach (SMALL_FOLDS[k]) begin
        cp = SMALL_FOLDS[k][23:8];
        ch = SMALL_FOLDS[k][7:0];
        base_of[cp] = ch;
        accented.push_back(cp);
        // capitals sit 0x20 lower in latin-1, one lower elsewhere
        cp = (cp < 16'h0100) ? cp - 16'h0020 : cp - 16'h0001;
        base_of[cp] = ch - 8'h20;
        accented.push_back(cp);
      end
      cont_left = PEND_NONE;
      code_acc  = '0;
    endfunction

    function void push_code(bit [15:0] cp);
      folded_char_t r;
      r.term = 1'b0;
      if (base_of.exists(cp)) begin
        r.chr = base_of[cp];
        n_folded++;
      end else
        r.chr = cp[7:0];
      chars_due.push_back(r);
    endfunction

    function void take_byte(bit [7:0] b);
      folded_char_t r;
      if (b == BYTE_NUL) begin
        cont_left = PEND_NONE;
        code_acc  = '0;
        r.chr  = BYTE_NUL;
        r.term = 1'b1;
        chars_due.push_back(r);
      end else if (cont_left != PEND_NONE) begin
        code_acc  = {code_acc[9:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == PEND_NONE)
          push_code(code_acc);
      end else if (!b[7])
        push_code({8'h00, b});
      else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        code_acc  = {11'd0, b[4:0]};
        cont_left = PEND_ONE;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        code_acc  = {12'd0, b[3:0]};
        cont_left = PEND_TWO;
      end else begin
        r.chr  = CHAR_UNKNOWN;
        r.term = 1'b0;
        chars_due.push_back(r);
      end
    endfunction

    function void match_char(logic [7:0] chr, logic term);
      folded_char_t e;
      n_checked++;
      if (chars_due.size() == 0) begin
        $error("unexpected item: out_char %h out_is_end %b", chr, term);
        n_errors++;
        return;
      end
      e = chars_due.pop_front();
      if (e.term)
        n_ends++;
      if (chr !== e.chr) begin
        $error("out_char: expected %h, got %h", e.chr, chr);
        n_errors++;
      end
      if (term !== e.term) begin
        $error("out_is_end: expected %b, got %b", e.term, term);
        n_errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_is_end;

  fold_tracker fold;
  tx_mode_t    tx_mode     = TX_STREAM;
  rx_mode_t    rx_mode     = RX_ALWAYS;
  int          burst_left  = 0;
  int          n_sent      = 0;
  int          idle_cycles = 0;
  int          rx_tick     = 0;

  utf8_vietnamese_diacritic_fold_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .out_is_end (out_is_end)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_ALWAYS:   out_ready <= 1'b1;
      RX_RANDOM:   out_ready <= ($urandom_range(0, 99) >= 30);
      RX_PERIODIC: out_ready <= ((rx_tick % 7) >= 3);
      default:     out_ready <= ((rx_tick % 32) < 4);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      fold.match_char(out_char, out_is_end);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("tb_utf8_vietnamese_diacritic_fold_top: done, errors");
      $finish;
    end
  end

  task automatic send_byte(input bit [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left <= 0) begin
      case (tx_mode)
        TX_STREAM: begin
          burst_left = 1000;
          gap = 0;
        end
        TX_BURSTY: begin
          burst_left = $urandom_range(1, 16);
          gap = $urandom_range(1, 5);
        end
        default: begin
          burst_left = $urandom_range(1, 3);
          gap = $urandom_range(0, 12);
        end
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_byte  <= 8'($urandom_range(0, 255));
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fold.take_byte(b);
    n_sent++;
    burst_left--;
  endtask

  // sender holds off until every predicted character has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (fold.chars_due.size() != 0) @(posedge clk);
  endtask

  function automatic bit [7:0] cont_byte(bit [5:0] bits, bit bent);
    bit [1:0] top;
    top = bent ? 2'($urandom_range(0, 3)) : 2'b10;
    return {top, bits};
  endfunction

  task automatic send_utf8(input bit [15:0] cp, input bit bent);
    if (cp < 16'h0800 && $urandom_range(0, 1)) begin
      send_byte({3'b110, cp[10:6]});
      send_byte(cont_byte(cp[5:0], bent));
    end else begin
      send_byte({4'b1110, cp[15:12]});
      send_byte(cont_byte(cp[11:6], bent));
      send_byte(cont_byte(cp[5:0], bent));
    end
  endtask

  task automatic send_token();
    int        pick;
    bit [15:0] cp;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      cp = fold.accented[$urandom_range(0, fold.accented.size() - 1)];
      send_utf8(cp, 1'b0);
    end else if (pick < 60)
      send_byte(8'($urandom_range(1, 127)));
    else if (pick < 72) begin
      cp = 16'($urandom);
      send_utf8(cp, $urandom_range(0, 3) == 0);
    end else if (pick < 77)
      send_byte(BYTE_NUL);
    else if (pick < 85) begin
      // sequence cut short by a terminator
      if ($urandom_range(0, 1))
        send_byte({3'b110, 5'($urandom_range(0, 31))});
      else begin
        send_byte({4'b1110, 4'($urandom_range(0, 15))});
        if ($urandom_range(0, 1))
          send_byte({2'b10, 6'($urandom_range(0, 63))});
      end
      send_byte(BYTE_NUL);
    end else
      send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int target;
    fold = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[k])
      send_byte(DIRECTED[k]);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      tx_mode = PHASE_TX[p];
      rx_mode = PHASE_RX[p];
      target  = n_sent + PHASE_BYTES;
      while (n_sent < target)
        send_token();
      drain();
    end

    repeat (8) @(posedge clk);
    if (fold.chars_due.size() != 0) begin
      $error("%0d characters never came out", fold.chars_due.size());
      fold.n_errors++;
    end

    $display("fed %0d bytes, checked %0d characters (%0d folded letters, %0d terminators)",
             n_sent, fold.n_checked, fold.n_folded, fold.n_ends);
    $display("sender gaps and receiver stalls varied over %0d phases, drained after each",
             N_PHASES);
    if (fold.n_errors == 0)
      $display("tb_utf8_vietnamese_diacritic_fold_top: done, clean");
    else
      $display("tb_utf8_vietnamese_diacritic_fold_top: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/uvdf_pkg.sv
rtl/uvdf_decode.sv
rtl/utf8_vietnamese_diacritic_fold_top.sv
tb/tb_utf8_vietnamese_diacritic_fold_top.sv
